// ----- rtl/core/sldec_pkg.sv -----
package sldec_pkg;

	// payload byte count at which the frame is aborted
	localparam int unsigned MAX_PAYLOAD = 256;
	localparam int unsigned OFF_W = $clog2(MAX_PAYLOAD + 1);
	localparam int unsigned LEN_CMP_W = 17;

	localparam logic [7:0] SYNC1 = 8'h5A;
	localparam logic [7:0] SYNC2 = 8'hA5;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB = 16'h8000;

	// frame status codes
	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_GOOD = 2'd1;
	localparam logic [1:0] ST_BAD_CRC = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic [1:0] frame_status;
		logic [31:0] good_frames;
		logic [31:0] bad_crc_frames;
	} result_t;

	// crc-16 0x1021 update by one byte, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] crc;
		crc = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((crc & CRC_MSB) != 16'h0000)
				crc = {crc[14:0], 1'b0} ^ CRC_POLY;
			else
				crc = {crc[14:0], 1'b0};
		end
		return crc;
	endfunction

	// crc after both sync bytes, starting from zero
	localparam logic [15:0] SYNC_CRC = crc_byte(crc_byte(16'h0000, SYNC1), SYNC2);

endpackage

// ----- rtl/core/sldec_if.sv -----
interface sldec_rx_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sldec_res_if;
	logic valid;
	logic ready;
	logic payload_valid;
	logic [7:0] payload_byte;
	logic [7:0] byte_index;
	logic [1:0] frame_status;
	logic [31:0] good_frames;
	logic [31:0] bad_crc_frames;

	modport source (output valid, output payload_valid, output payload_byte,
		output byte_index, output frame_status, output good_frames,
		output bad_crc_frames, input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input byte_index, input frame_status, input good_frames,
		input bad_crc_frames, output ready);
endinterface

// ----- rtl/core/sldec_core.sv -----
module sldec_core
	import sldec_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [7:0] byte_in,
	output result_t result
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_SYNC2 = 3'd1;
	localparam logic [2:0] PH_LEN_LO = 3'd2;
	localparam logic [2:0] PH_LEN_HI = 3'd3;
	localparam logic [2:0] PH_CRC_LO = 3'd4;
	localparam logic [2:0] PH_CRC_HI = 3'd5;
	localparam logic [2:0] PH_DATA = 3'd6;

	logic [2:0] phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [15:0] exp_crc_q, exp_crc_d;
	logic [15:0] crc_q, crc_d;
	logic [OFF_W-1:0] off_q, off_d;
	logic [31:0] good_q, good_d;
	logic [31:0] bad_q, bad_d;
	logic [15:0] crc_upd;
	logic [OFF_W-1:0] off_inc;

	assign crc_upd = crc_byte(crc_q, byte_in);
	assign off_inc = off_q + OFF_W'(1);

	// next state and result for the byte at hand
	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		exp_crc_d = exp_crc_q;
		crc_d = crc_q;
		off_d = off_q;
		good_d = good_q;
		bad_d = bad_q;
		result.payload_valid = 1'b0;
		result.payload_byte = 8'h00;
		result.byte_index = 8'h00;
		result.frame_status = ST_NONE;
		case (phase_q)
			PH_IDLE: begin
				if (byte_in == SYNC1)
					phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (byte_in == SYNC2) begin
					crc_d = SYNC_CRC;
					phase_d = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				len_d = {8'h00, byte_in};
				crc_d = crc_upd;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d = {byte_in, len_q[7:0]};
				crc_d = crc_upd;
				phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				exp_crc_d = {8'h00, byte_in};
				phase_d = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				exp_crc_d = {byte_in, exp_crc_q[7:0]};
				off_d = '0;
				phase_d = PH_DATA;
			end
			PH_DATA: begin
				result.payload_valid = 1'b1;
				result.payload_byte = byte_in;
				result.byte_index = 8'(off_q);
				crc_d = crc_upd;
				off_d = off_inc;
				// buffer limit is checked ahead of the length
				if (LEN_CMP_W'(off_inc) >= LEN_CMP_W'(MAX_PAYLOAD)) begin
					result.frame_status = ST_OVERFLOW;
					phase_d = PH_IDLE;
				end else if (LEN_CMP_W'(off_inc) >= LEN_CMP_W'(len_q)) begin
					if (crc_upd == exp_crc_q) begin
						good_d = good_q + 32'd1;
						result.frame_status = ST_GOOD;
					end else begin
						bad_d = bad_q + 32'd1;
						result.frame_status = ST_BAD_CRC;
					end
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		result.good_frames = good_d;
		result.bad_crc_frames = bad_d;
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q <= '0;
			exp_crc_q <= '0;
			crc_q <= '0;
			off_q <= '0;
			good_q <= '0;
			bad_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			len_q <= len_d;
			exp_crc_q <= exp_crc_d;
			crc_q <= crc_d;
			off_q <= off_d;
			good_q <= good_d;
			bad_q <= bad_d;
		end
	end

endmodule

// ----- rtl/core/sync_length_crc_frame_decoder_top.sv -----
// path: a byte accepted is held in the input register, and its result is written to the
//   result register when the core steps on it, which waits while that register is full
// throughput: one byte per clock, held off only while the result register is full
//   and not being taken; the crc update and frame checks are combinational
// reset: phase returns to sync hunting, length, crcs, offset and frame
//   counters clear, and no result is pending
module sync_length_crc_frame_decoder_top
	import sldec_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sldec_rx_if.sink rx,
	sldec_res_if.source res
);

	logic valid_s1;
	logic [7:0] rx_byte_s1;
	logic res_valid_q;
	result_t res_q;
	result_t res_d;
	logic advance;
	logic step;

	assign advance = !res_valid_q || res.ready;
	assign step = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			rx_byte_s1 <= rx.rx_byte;
	end

	sldec_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (rx_byte_s1),
		.result  (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res_d;
	end

	assign res.valid = res_valid_q;
	assign res.payload_valid = res_q.payload_valid;
	assign res.payload_byte = res_q.payload_byte;
	assign res.byte_index = res_q.byte_index;
	assign res.frame_status = res_q.frame_status;
	assign res.good_frames = res_q.good_frames;
	assign res.bad_crc_frames = res_q.bad_crc_frames;

endmodule
